FILE: rtl/smdf_pkg.sv
// smdf_pkg: constants, types and register codes for the sensor mean decimal formatter
// used by rtl/sensor_mean_decimal_formatter_top.sv and rtl/smdf_checker.sv
// no dependencies
package smdf_pkg;

  // block configuration
  localparam int SAMPLES_PER_MEAN = 6;
  localparam int SAMPLE_BITS      = 10;

  localparam int GROUP_SIZE  = (SAMPLES_PER_MEAN < 1) ? 1 : SAMPLES_PER_MEAN;
  localparam int SCALE_BITS  = 8;
  localparam int OFFSET_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CHAR_BITS   = 8;

  // group accumulator sized so that a full group never wraps
  localparam int SUM_BITS   = $clog2(GROUP_SIZE * (2**SAMPLE_BITS - 1) + 1);
  localparam int COUNT_BITS = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

  // floor(sum / GROUP_SIZE) as (sum * RECIP_MULT) >> RECIP_SHIFT, exact for sum < 2**SUM_BITS
  localparam int RECIP_SHIFT = SUM_BITS + $clog2(GROUP_SIZE);
  localparam int RECIP_MULT  = (2**RECIP_SHIFT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int RECIP_BITS  = $clog2(RECIP_MULT + 1);
  localparam int RECIP_PROD_BITS = SUM_BITS + RECIP_BITS;

  localparam int PROD_BITS = SAMPLE_BITS + SCALE_BITS;
  localparam int DIFF_BITS = (PROD_BITS > OFFSET_BITS) ? PROD_BITS : OFFSET_BITS;

  // shown value after saturation
  localparam int VALUE_BITS  = 14;
  localparam int VALUE_LIMIT = 9999;

  // decimal split by reciprocal multiply, exact for values up to VALUE_LIMIT
  localparam int DIGIT_MULT_BITS = 15;
  localparam int DIGIT_PROD_BITS = VALUE_BITS + DIGIT_MULT_BITS;
  localparam int DIV10_MULT     = 26215;
  localparam int DIV10_SHIFT    = 18;
  localparam int DIV100_MULT    = 20972;
  localparam int DIV100_SHIFT   = 21;
  localparam int DIV1000_MULT   = 16778;
  localparam int DIV1000_SHIFT  = 24;
  localparam int Q1000_BITS = 4;
  localparam int Q100_BITS  = 7;
  localparam int Q10_BITS   = 10;
  localparam int DIGIT_BITS = 4;

  typedef logic [CHAR_BITS-1:0] char_t;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  // register reset values
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 8'd49;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 16'd27310;

  // register indexes
  localparam int CFG_INDEX_BITS = 1;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SCALE_FACTOR = 1'b0,
    CFG_ZERO_OFFSET  = 1'b1
  } cfg_index_t;

endpackage

FILE: rtl/sensor_mean_decimal_formatter_top.sv
// sensor_mean_decimal_formatter_top: group averaging, scaling, offset and ascii digit pipeline
// depends on rtl/smdf_pkg.sv

// One sample word is taken every cycle while sample_ready is high. Samples are
// summed in groups of SAMPLES_PER_MEAN; the sample that closes a group carries
// the mode for the whole group and launches a six-stage pipeline: truncating
// mean by reciprocal multiply, scaling, offset magnitude with sign in offset
// mode, saturation to 9999, decimal split, ascii formatting into the result
// register, with one result per group. Each stage holds its word until the
// next one is free, so sample_ready only drops for a group-closing sample when
// the first stage is still occupied by a stalled word. Configuration writes
// land in the cycle after cfg_write and should be made with the pipeline empty.
module sensor_mean_decimal_formatter_top (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic [smdf_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic                                offset_mode,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [smdf_pkg::CHAR_BITS-1:0]      sign_char,
  output logic [smdf_pkg::CHAR_BITS-1:0]      thousands_char,
  output logic [smdf_pkg::CHAR_BITS-1:0]      hundreds_char,
  output logic [smdf_pkg::CHAR_BITS-1:0]      tens_char,
  output logic                                over_range,
  output logic                                mode_used,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [smdf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [smdf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import smdf_pkg::*;

  // configuration registers
  logic [SCALE_BITS-1:0]  scale_factor;
  logic [OFFSET_BITS-1:0] zero_offset;

  // group accumulator
  logic [SUM_BITS-1:0]   sample_sum;
  logic [COUNT_BITS-1:0] sample_count;

  // stage 1: completed group sum
  logic                s1_valid;
  logic [SUM_BITS-1:0] s1_sum;
  logic                s1_mode;
  // stage 2: mean
  logic                   s2_valid;
  logic [SAMPLE_BITS-1:0] s2_mean;
  logic                   s2_mode;
  // stage 3: scaled mean
  logic                 s3_valid;
  logic [PROD_BITS-1:0] s3_prod;
  logic                 s3_mode;
  // stage 4: saturated magnitude with sign
  logic                  s4_valid;
  logic [VALUE_BITS-1:0] s4_value;
  logic                  s4_minus;
  logic                  s4_over;
  logic                  s4_mode;
  // stage 5: quotients by 1000, 100 and 10
  logic                  s5_valid;
  logic [Q1000_BITS-1:0] s5_q1000;
  logic [Q100_BITS-1:0]  s5_q100;
  logic [Q10_BITS-1:0]   s5_q10;
  logic                  s5_minus;
  logic                  s5_over;
  logic                  s5_mode;

  // stage handshakes: a stage loads when the one before holds a word and it is free
  logic go1, go2, go3, go4, go5, go_out;
  logic free1, free2, free3, free4, free5;
  logic accept, group_done;

  logic [SUM_BITS-1:0]        sum_total;
  logic [RECIP_PROD_BITS-1:0] recip_prod;
  logic [PROD_BITS-1:0]       scaled;
  logic [DIFF_BITS-1:0]       prod_ext, offset_ext, diff;
  logic                       diff_minus;
  logic                       diff_over;
  logic [DIGIT_PROD_BITS-1:0] p1000, p100, p10;
  logic [DIGIT_BITS-1:0]      d1000, d100, d10;

  assign go_out = s5_valid && (!result_valid || result_ready);
  assign free5  = !s5_valid || go_out;
  assign go5    = s4_valid && free5;
  assign free4  = !s4_valid || go5;
  assign go4    = s3_valid && free4;
  assign free3  = !s3_valid || go4;
  assign go3    = s2_valid && free3;
  assign free2  = !s2_valid || go3;
  assign go2    = s1_valid && free2;
  assign free1  = !s1_valid || go2;

  assign group_done   = (sample_count == COUNT_BITS'(GROUP_SIZE - 1));
  // only the closing sample needs room downstream
  assign sample_ready = !group_done || free1;
  assign accept       = sample_valid && sample_ready;
  assign go1          = accept && group_done;

  assign sum_total = sample_sum + SUM_BITS'(sample);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_RESET;
      zero_offset  <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCALE_FACTOR: scale_factor <= cfg_data[SCALE_BITS-1:0];
        CFG_ZERO_OFFSET:  zero_offset  <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // accumulate samples, restart on group close
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (group_done) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_total;
        sample_count <= sample_count + COUNT_BITS'(1);
      end
    end
  end

  // mean by reciprocal multiply
  assign recip_prod = RECIP_PROD_BITS'(s1_sum) * RECIP_PROD_BITS'(RECIP_MULT);

  // scaling
  assign scaled = PROD_BITS'(s2_mean) * PROD_BITS'(scale_factor);

  // offset magnitude and saturation
  assign prod_ext   = DIFF_BITS'(s3_prod);
  assign offset_ext = DIFF_BITS'(zero_offset);
  always_comb begin
    diff_minus = 1'b0;
    diff       = prod_ext;
    if (s3_mode) begin
      if (prod_ext >= offset_ext) begin
        diff = prod_ext - offset_ext;
      end else begin
        diff       = offset_ext - prod_ext;
        diff_minus = 1'b1;
      end
    end
  end
  assign diff_over = (diff > DIFF_BITS'(VALUE_LIMIT));

  // decimal quotients
  assign p1000 = DIGIT_PROD_BITS'(s4_value) * DIGIT_PROD_BITS'(DIV1000_MULT);
  assign p100  = DIGIT_PROD_BITS'(s4_value) * DIGIT_PROD_BITS'(DIV100_MULT);
  assign p10   = DIGIT_PROD_BITS'(s4_value) * DIGIT_PROD_BITS'(DIV10_MULT);

  // digits from neighboring quotients
  assign d1000 = s5_q1000;
  assign d100  = DIGIT_BITS'(s5_q100 - Q100_BITS'(s5_q1000) * Q100_BITS'(10));
  assign d10   = DIGIT_BITS'(s5_q10 - Q10_BITS'(s5_q100) * Q10_BITS'(10));

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (go1) begin
        s1_valid <= 1'b1;
      end else if (go2) begin
        s1_valid <= 1'b0;
      end
      if (go2) begin
        s2_valid <= 1'b1;
      end else if (go3) begin
        s2_valid <= 1'b0;
      end
      if (go3) begin
        s3_valid <= 1'b1;
      end else if (go4) begin
        s3_valid <= 1'b0;
      end
      if (go4) begin
        s4_valid <= 1'b1;
      end else if (go5) begin
        s4_valid <= 1'b0;
      end
      if (go5) begin
        s5_valid <= 1'b1;
      end else if (go_out) begin
        s5_valid <= 1'b0;
      end
      if (go_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (go1) begin
      s1_sum  <= sum_total;
      s1_mode <= offset_mode;
    end
    if (go2) begin
      s2_mean <= recip_prod[RECIP_SHIFT +: SAMPLE_BITS];
      s2_mode <= s1_mode;
    end
    if (go3) begin
      s3_prod <= scaled;
      s3_mode <= s2_mode;
    end
    if (go4) begin
      s4_value <= diff_over ? VALUE_BITS'(VALUE_LIMIT) : diff[VALUE_BITS-1:0];
      s4_minus <= diff_minus;
      s4_over  <= diff_over;
      s4_mode  <= s3_mode;
    end
    if (go5) begin
      s5_q1000 <= p1000[DIV1000_SHIFT +: Q1000_BITS];
      s5_q100  <= p100[DIV100_SHIFT +: Q100_BITS];
      s5_q10   <= p10[DIV10_SHIFT +: Q10_BITS];
      s5_minus <= s4_minus;
      s5_over  <= s4_over;
      s5_mode  <= s4_mode;
    end
    if (go_out) begin
      sign_char      <= s5_minus ? CH_MINUS : CH_SPACE;
      // blank a leading thousands digit
      thousands_char <= (s5_q1000 == '0) ? CH_SPACE : CH_ZERO + CHAR_BITS'(d1000);
      hundreds_char  <= CH_ZERO + CHAR_BITS'(d100);
      tens_char      <= CH_ZERO + CHAR_BITS'(d10);
      over_range     <= s5_over;
      mode_used      <= s5_mode;
    end
  end

endmodule

FILE: rtl/smdf_checker.sv
// smdf_checker: port-level assertions for sensor_mean_decimal_formatter_top, with its bind
// depends on rtl/smdf_pkg.sv and rtl/sensor_mean_decimal_formatter_top.sv
module smdf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [smdf_pkg::CHAR_BITS-1:0] sign_char,
  input logic [smdf_pkg::CHAR_BITS-1:0] thousands_char,
  input logic [smdf_pkg::CHAR_BITS-1:0] hundreds_char,
  input logic [smdf_pkg::CHAR_BITS-1:0] tens_char,
  input logic                           over_range,
  input logic                           mode_used
);
  import smdf_pkg::*;

  // a pending result word holds until taken, checked on its sign and tens chars
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(tens_char) && $stable(sign_char))
    else $error("result word dropped or changed while stalled");

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // saturated values show as 999 in the visible digits
  a_over_nines: assert property (@(posedge clk) disable iff (rst)
    result_valid && over_range |->
      thousands_char == CH_NINE && hundreds_char == CH_NINE && tens_char == CH_NINE)
    else $error("saturated result not shown as nines");

  // plain mode never shows a minus
  a_plain_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid && !mode_used |-> sign_char == CH_SPACE)
    else $error("minus sign in plain mode");

  // a leading thousands digit is blanked, never shown as zero
  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> thousands_char != CH_ZERO)
    else $error("thousands digit shown as zero");

endmodule

bind sensor_mean_decimal_formatter_top smdf_checker u_smdf_checker (.*);

FILE: tb/sensor_mean_decimal_formatter_top_test.sv
// sensor_mean_decimal_formatter_top_test: self-checking bench for the group mean formatter
// drives random sample words and configuration settings, predicts every ascii readout
// depends on rtl/smdf_pkg.sv and rtl/sensor_mean_decimal_formatter_top.sv
module sensor_mean_decimal_formatter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smdf_pkg::*;

  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int STALL_LIMIT = 3000;  // cycles with no word moving before giving up
  localparam int LONG_HOLD   = 600;   // receiver back-pressure stretch
  localparam int PHASES      = 8;
  localparam int PHASE_GROUPS = 40;

  // one formatted readout as seen on the result channel
  typedef struct packed {
    char_t sign;
    char_t thousands;
    char_t hundreds;
    char_t tens;
    logic  over;
    logic  mode;
  } readout_t;

  // group accumulator mirror, register copies and the queue of pending readouts
  class mean_scoreboard;
    logic [SUM_BITS-1:0]    sum_acc = '0;
    int                     count = 0;
    logic [SCALE_BITS-1:0]  scale = SCALE_RESET;
    logic [OFFSET_BITS-1:0] offset = OFFSET_RESET;
    readout_t               expected_readouts[$];
    int mismatches = 0;
    int samples_seen = 0;
    int readouts_seen = 0;
    int offset_seen = 0;
    int negative_seen = 0;
    int saturated_seen = 0;

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
      unique case (idx)
        CFG_SCALE_FACTOR: scale = data[SCALE_BITS-1:0];
        CFG_ZERO_OFFSET:  offset = data[OFFSET_BITS-1:0];
        default: ;
      endcase
    endfunction

    // scale the mean, fold around the offset, saturate and split into digits
    function readout_t format_mean(int unsigned mean, logic mode);
      readout_t r;
      int unsigned prod;
      int unsigned shown;
      prod = mean * scale;
      shown = prod;
      r.sign = CH_SPACE;
      if (mode) begin
        if (prod >= offset) begin
          shown = prod - offset;
        end else begin
          shown = offset - prod;
          r.sign = CH_MINUS;
        end
      end
      r.over = (shown > VALUE_LIMIT);
      if (r.over) begin
        shown = VALUE_LIMIT;
      end
      r.thousands = (shown >= 1000) ? char_t'(CH_ZERO + (shown / 1000) % 10) : CH_SPACE;
      r.hundreds = char_t'(CH_ZERO + (shown / 100) % 10);
      r.tens = char_t'(CH_ZERO + (shown / 10) % 10);
      r.mode = mode;
      return r;
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] s, logic mode);
      samples_seen++;
      sum_acc += s;
      count++;
      if (count == GROUP_SIZE) begin
        expected_readouts.push_back(format_mean(sum_acc / GROUP_SIZE, mode));
        sum_acc = '0;
        count = 0;
      end
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_readout(readout_t got);
      readout_t exp;
      if (expected_readouts.size() == 0) begin
        $error("readout word with no completed group pending");
        mismatches++;
        return;
      end
      exp = expected_readouts.pop_front();
      readouts_seen++;
      if (exp.mode) offset_seen++;
      if (exp.sign == CH_MINUS) negative_seen++;
      if (exp.over) saturated_seen++;
      check_field("sign_char", exp.sign, got.sign);
      check_field("thousands_char", exp.thousands, got.thousands);
      check_field("hundreds_char", exp.hundreds, got.hundreds);
      check_field("tens_char", exp.tens, got.tens);
      check_field("over_range", exp.over, got.over);
      check_field("mode_used", exp.mode, got.mode);
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        sample_valid;
  logic                        sample_ready;
  logic [SAMPLE_BITS-1:0]      sample;
  logic                        offset_mode;
  logic                        result_valid;
  logic                        result_ready;
  char_t                       sign_char;
  char_t                       thousands_char;
  char_t                       hundreds_char;
  char_t                       tens_char;
  logic                        over_range;
  logic                        mode_used;
  logic                        cfg_write;
  logic [CFG_INDEX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_data;

  mean_scoreboard sb;
  bit send_quiet;   // sender in a stretch with no gaps
  bit recv_quiet;   // receiver in a stretch with no stalls
  int idle_cycles;
  int settings_used;

  sensor_mean_decimal_formatter_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .offset_mode    (offset_mode),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .sign_char      (sign_char),
    .thousands_char (thousands_char),
    .hundreds_char  (hundreds_char),
    .tens_char      (tens_char),
    .over_range     (over_range),
    .mode_used      (mode_used),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // watchdog: any word moving or any register write resets the count
  always @(posedge clk) begin
    if (rst || cfg_write || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // random gap before the next word, with occasional runs of back-to-back words
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_BITS'(SAMPLE_MAX);
    return SAMPLE_BITS'(v);
  endfunction

  // offer one sample word and hold it until the block takes it
  task automatic offer_sample(logic [SAMPLE_BITS-1:0] s, logic m);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    offset_mode <= m;
    do @(posedge clk); while (!sample_ready);
    sb.take_sample(s, m);
  endtask

  // one group of samples; most groups are clustered so the readout lands in
  // an interesting range, a few are fully random
  task automatic offer_random_group();
    int kind;
    int centre;
    int jitter;
    logic gm;
    logic m;
    logic [SAMPLE_BITS-1:0] s;
    kind = $urandom_range(0, 9);
    gm = 1'($urandom_range(0, 1));
    centre = 0;
    jitter = 0;
    unique case (kind)
      3, 4, 5: begin
        centre = $urandom_range(0, SAMPLE_MAX);
        jitter = 3;
      end
      6, 7: begin
        // mean close to offset / scale so the product straddles the offset
        centre = (sb.scale == 0) ? 0 : int'(sb.offset / sb.scale);
        jitter = 2;
        gm = 1'b1;
      end
      8: centre = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      9: begin
        centre = $urandom_range(0, 10000 / (int'(sb.scale) + 1));
        jitter = 1;
      end
      default: ;
    endcase
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (kind <= 2) begin
        s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      end else begin
        s = clamp_sample(centre + int'($urandom_range(0, 2 * jitter)) - jitter);
      end
      // only the closing word's mode matters; earlier words sometimes disagree
      m = (i == GROUP_SIZE - 1 || $urandom_range(0, 3) != 0) ? gm : !gm;
      offer_sample(s, m);
    end
  endtask

  // sender stops and waits for every pending readout, then lets the pipe drain
  task automatic settle_idle();
    sample_valid <= 1'b0;
    while (sb.expected_readouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // back-to-back writes of both registers, write enable stays high between them
  task automatic load_settings(logic [SCALE_BITS-1:0] scale, logic [OFFSET_BITS-1:0] offset);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SCALE_FACTOR;
    cfg_data <= CFG_DATA_BITS'(scale);
    @(posedge clk);
    sb.write_reg(CFG_SCALE_FACTOR, CFG_DATA_BITS'(scale));
    cfg_index <= CFG_ZERO_OFFSET;
    cfg_data <= offset;
    @(posedge clk);
    sb.write_reg(CFG_ZERO_OFFSET, offset);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // result side: random stalls, two long holds in the middle of busy phases
  // so the pipe backs up into the input
  task automatic drain_readouts();
    int gap;
    readout_t got;
    forever begin
      if (sb.readouts_seen == 24 || sb.readouts_seen == 104) begin
        gap = LONG_HOLD;
      end else begin
        gap = draw_gap(recv_quiet);
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      got.sign = sign_char;
      got.thousands = thousands_char;
      got.hundreds = hundreds_char;
      got.tens = tens_char;
      got.over = over_range;
      got.mode = mode_used;
      sb.check_readout(got);
    end
  endtask

  // register settings per phase; the last two are drawn at random
  logic [SCALE_BITS-1:0]  phase_scale[PHASES]  = '{0, 255, 1, 255, 0, 7, 49, 49};
  logic [OFFSET_BITS-1:0] phase_offset[PHASES] = '{0, 65535, 0, 0, 40000, 1234, 0, 0};

  initial begin
    sb = new;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    settings_used = 1;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    offset_mode <= 1'b0;
    result_ready <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_SCALE_FACTOR;
    cfg_data <= '0;
    phase_scale[6] = SCALE_BITS'($urandom_range(1, 255));
    phase_offset[6] = OFFSET_BITS'($urandom_range(0, 65535));
    phase_scale[7] = SCALE_BITS'($urandom_range(1, 255));
    phase_offset[7] = OFFSET_BITS'($urandom_range(0, 65535));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    fork
      drain_readouts();
    join_none

    // directed groups at the reset settings
    // zero value: blank thousands, '0' hundreds and tens
    repeat (GROUP_SIZE) offer_sample('0, 1'b0);
    // full scale in plain mode saturates
    repeat (GROUP_SIZE) offer_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
    // mixed modes, closing word in offset mode, product just under the offset
    offer_sample(SAMPLE_BITS'(557), 1'b1);
    offer_sample(SAMPLE_BITS'(557), 1'b0);
    offer_sample(SAMPLE_BITS'(557), 1'b1);
    offer_sample(SAMPLE_BITS'(557), 1'b0);
    offer_sample(SAMPLE_BITS'(557), 1'b0);
    offer_sample(SAMPLE_BITS'(557), 1'b1);
    // truncating mean, closing word in plain mode overrides the others
    for (int i = 0; i < GROUP_SIZE; i++) begin
      offer_sample(SAMPLE_BITS'((i % 2 == 0) ? 100 : 101),
                   (i == GROUP_SIZE - 1) ? 1'b0 : 1'b1);
    end

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      load_settings(phase_scale[p], phase_offset[p]);
      repeat (PHASE_GROUPS) offer_random_group();
    end

    settle_idle();
    repeat (12) @(posedge clk);

    $display("run covered %0d sample words and %0d readouts over %0d register settings",
             sb.samples_seen, sb.readouts_seen, settings_used);
    $display("readouts: %0d in offset mode, %0d negative, %0d saturated",
             sb.offset_seen, sb.negative_seen, sb.saturated_seen);
    if (sb.mismatches == 0 && sb.expected_readouts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/smdf_pkg.sv
rtl/sensor_mean_decimal_formatter_top.sv
rtl/smdf_checker.sv
tb/sensor_mean_decimal_formatter_top_test.sv
